>>> rtl/core/gdmc_pkg.sv
// ----------------------------------------------------------------------------
// Gate door motion controller package
// Shared types, codes and timing constants for the door controller.
// ----------------------------------------------------------------------------
package gdmc_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;

  localparam int unsigned TIME_W    = 13;
  localparam int unsigned OPEN_EL_W = 17;
  localparam int unsigned LIMIT_W   = 9;
  localparam int unsigned AUTO_W    = 7;
  localparam int unsigned DRIVE_W   = 8;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [TIME_W-1:0]    TIME_MAX    = {TIME_W{1'b1}};
  localparam logic [OPEN_EL_W-1:0] OPEN_EL_MAX = {OPEN_EL_W{1'b1}};

  localparam logic signed [DRIVE_W-1:0] DRIVE_STOP  = 8'sd0;
  localparam logic signed [DRIVE_W-1:0] DRIVE_OPEN  = 8'sd80;
  localparam logic signed [DRIVE_W-1:0] DRIVE_CLOSE = -8'sd80;
  localparam logic signed [DRIVE_W-1:0] DRIVE_BACK  = -8'sd60;

  // Request opcodes.
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_OPEN     = 3'd1,
    OP_CLOSE    = 3'd2,
    OP_STOP     = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_DISTANCE = 3'd5
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_TRAVEL  = 3'd0,
    REG_CLOSE_TRAVEL = 3'd1,
    REG_RETREAT      = 3'd2,
    REG_OBST_LIMIT   = 3'd3,
    REG_AUTO_CLOSE   = 3'd4
  } reg_idx_t;

  // Door state machine, one-hot.
  typedef enum logic [5:0] {
    GATE_CLOSED  = 6'b000001,
    GATE_OPENING = 6'b000010,
    GATE_OPEN    = 6'b000100,
    GATE_CLOSING = 6'b001000,
    GATE_BLOCKED = 6'b010000,
    GATE_FAULT   = 6'b100000
  } door_mode_t;

  // Reported door state codes.
  localparam logic [2:0] STATE_CLOSED  = 3'd0;
  localparam logic [2:0] STATE_OPENING = 3'd1;
  localparam logic [2:0] STATE_OPEN    = 3'd2;
  localparam logic [2:0] STATE_CLOSING = 3'd3;
  localparam logic [2:0] STATE_BLOCKED = 3'd4;
  localparam logic [2:0] STATE_FAULT   = 3'd5;

  // Event codes.
  localparam logic [1:0] EVT_NONE       = 2'd0;
  localparam logic [1:0] EVT_OBSTACLE   = 2'd1;
  localparam logic [1:0] EVT_AUTO_CLOSE = 2'd2;

  function automatic logic [2:0] state_code(door_mode_t mode);
    logic [2:0] code;
    unique case (mode)
      GATE_CLOSED:  code = STATE_CLOSED;
      GATE_OPENING: code = STATE_OPENING;
      GATE_OPEN:    code = STATE_OPEN;
      GATE_CLOSING: code = STATE_CLOSING;
      GATE_BLOCKED: code = STATE_BLOCKED;
      GATE_FAULT:   code = STATE_FAULT;
      default:      code = STATE_CLOSED;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/core/gate_door_motion_controller_unit.sv
// Results: each result is registered into the output buffer when its request is taken.
// Throughput: one request per cycle while the skid is empty; the door state update is a single
// compare-and-update stage; a two-entry output buffer takes one more request on a stall.
// Reset: synchronous, active high; door closed, motor stopped, all elapsed counters zero,
// configuration back to its defaults, output buffer empty.
// ----------------------------------------------------------------------------
// Gate door motion controller
// Timed open and close travel, obstacle retreat and auto-close, one event per request.
// ----------------------------------------------------------------------------
module gate_door_motion_controller_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gdmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gdmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Event requests.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: range_mm [12:0], range_valid [13], zero fill [15:14]
  input  logic [gdmc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: opcode [2:0]
  input  logic [2:0]                         s_axis_tuser,
  // Results.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: state [2:0], motor_drive [10:3], accepted [11], event_code [13:12],
  //        backing_off [14], zero fill [15]
  output logic [gdmc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import gdmc_pkg::*;

  // Configuration registers.
  logic [TIME_W-1:0]    open_travel_ms;
  logic [TIME_W-1:0]    close_travel_ms;
  logic [TIME_W-1:0]    retreat_ms;
  logic [LIMIT_W-1:0]   obstacle_limit_mm;
  logic [AUTO_W-1:0]    auto_close_seconds;
  logic [OPEN_EL_W-1:0] auto_close_ticks;

  // Door state.
  door_mode_t               door_mode, door_mode_next;
  logic                     retreat_active, retreat_active_next;
  logic signed [DRIVE_W-1:0] drive_level, drive_level_next;
  logic [TIME_W-1:0]        travel_elapsed, travel_elapsed_next;
  logic [OPEN_EL_W-1:0]     open_elapsed, open_elapsed_next;
  logic [TIME_W-1:0]        retreat_elapsed, retreat_elapsed_next;

  logic                     accepted;
  logic [1:0]               event_code;

  logic [TIME_W-1:0]        travel_inc;
  logic [TIME_W-1:0]        retreat_inc;
  logic [OPEN_EL_W-1:0]     open_inc;

  logic [TIME_W-1:0]        range_mm;
  logic                     range_valid;
  logic                     refused;
  logic                     in_fire;
  logic [OUT_DATA_W-1:0]    result;

  // Output buffer: main register plus skid entry.
  logic                     out_valid;
  logic [OUT_DATA_W-1:0]    out_data;
  logic                     skid_valid;
  logic [OUT_DATA_W-1:0]    skid_data;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign range_mm    = s_axis_tdata[TIME_W-1:0];
  assign range_valid = s_axis_tdata[TIME_W];

  assign travel_inc  = (travel_elapsed == TIME_MAX) ? TIME_MAX : travel_elapsed + 1'b1;
  assign retreat_inc = (retreat_elapsed == TIME_MAX) ? TIME_MAX : retreat_elapsed + 1'b1;
  assign open_inc    = (open_elapsed == OPEN_EL_MAX) ? OPEN_EL_MAX : open_elapsed + 1'b1;

  assign refused = (door_mode == GATE_BLOCKED) || (door_mode == GATE_FAULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      open_travel_ms     <= TIME_W'(1500);
      close_travel_ms    <= TIME_W'(1500);
      retreat_ms         <= TIME_W'(800);
      obstacle_limit_mm  <= LIMIT_W'(80);
      auto_close_seconds <= AUTO_W'(30);
      auto_close_ticks   <= OPEN_EL_W'(30 * TICKS_PER_SECOND);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OPEN_TRAVEL:  open_travel_ms    <= cfg_data[TIME_W-1:0];
        REG_CLOSE_TRAVEL: close_travel_ms   <= cfg_data[TIME_W-1:0];
        REG_RETREAT:      retreat_ms        <= cfg_data[TIME_W-1:0];
        REG_OBST_LIMIT:   obstacle_limit_mm <= cfg_data[LIMIT_W-1:0];
        REG_AUTO_CLOSE: begin
          auto_close_seconds <= cfg_data[AUTO_W-1:0];
          // The auto-close limit in ticks is kept ready so the tick path only compares.
          auto_close_ticks   <= OPEN_EL_W'(cfg_data[AUTO_W-1:0] * TICKS_PER_SECOND);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    door_mode_next       = door_mode;
    retreat_active_next  = retreat_active;
    drive_level_next     = drive_level;
    travel_elapsed_next  = travel_elapsed;
    open_elapsed_next    = open_elapsed;
    retreat_elapsed_next = retreat_elapsed;
    accepted             = 1'b1;
    event_code           = EVT_NONE;

    unique case (s_axis_tuser)
      OP_TICK: begin
        if ((door_mode == GATE_BLOCKED) && retreat_active) begin
          retreat_elapsed_next = retreat_inc;
          if (retreat_inc >= retreat_ms) begin
            retreat_active_next = 1'b0;
            drive_level_next    = DRIVE_STOP;
          end
        end else if (door_mode == GATE_OPENING) begin
          travel_elapsed_next = travel_inc;
          if (travel_inc >= open_travel_ms) begin
            drive_level_next  = DRIVE_STOP;
            door_mode_next    = GATE_OPEN;
            open_elapsed_next = '0;
          end
        end else if (door_mode == GATE_CLOSING) begin
          travel_elapsed_next = travel_inc;
          if (travel_inc >= close_travel_ms) begin
            drive_level_next  = DRIVE_STOP;
            door_mode_next    = GATE_CLOSED;
            open_elapsed_next = '0;
          end
        end else if (door_mode == GATE_OPEN) begin
          open_elapsed_next = open_inc;
          if ((auto_close_seconds != '0) && (open_inc >= auto_close_ticks)) begin
            retreat_active_next = 1'b0;
            door_mode_next      = GATE_CLOSING;
            travel_elapsed_next = '0;
            open_elapsed_next   = '0;
            drive_level_next    = DRIVE_CLOSE;
            event_code          = EVT_AUTO_CLOSE;
          end
        end
      end
      OP_OPEN: begin
        if (refused) begin
          accepted = 1'b0;
        end else if ((door_mode != GATE_OPEN) && (door_mode != GATE_OPENING)) begin
          retreat_active_next = 1'b0;
          door_mode_next      = GATE_OPENING;
          travel_elapsed_next = '0;
          drive_level_next    = DRIVE_OPEN;
        end
      end
      OP_CLOSE: begin
        if (refused) begin
          accepted = 1'b0;
        end else if ((door_mode != GATE_CLOSED) && (door_mode != GATE_CLOSING)) begin
          retreat_active_next = 1'b0;
          door_mode_next      = GATE_CLOSING;
          travel_elapsed_next = '0;
          open_elapsed_next   = '0;
          drive_level_next    = DRIVE_CLOSE;
        end
      end
      OP_STOP: begin
        // The retreat flag is left alone; the drive stops and an opening or closing door becomes open or closed.
        drive_level_next = DRIVE_STOP;
        if (door_mode == GATE_OPENING) begin
          door_mode_next    = GATE_OPEN;
          open_elapsed_next = '0;
        end else if (door_mode == GATE_CLOSING) begin
          door_mode_next    = GATE_CLOSED;
          open_elapsed_next = '0;
        end
      end
      OP_CLEAR: begin
        drive_level_next    = DRIVE_STOP;
        retreat_active_next = 1'b0;
        door_mode_next      = GATE_CLOSED;
        open_elapsed_next   = '0;
      end
      OP_DISTANCE: begin
        if ((door_mode == GATE_OPENING) && range_valid &&
            (range_mm < {{(TIME_W-LIMIT_W){1'b0}}, obstacle_limit_mm})) begin
          door_mode_next       = GATE_BLOCKED;
          retreat_active_next  = 1'b1;
          retreat_elapsed_next = '0;
          open_elapsed_next    = '0;
          drive_level_next     = DRIVE_BACK;
          event_code           = EVT_OBSTACLE;
        end
      end
      default: ;
    endcase
  end

  assign result = {1'b0, retreat_active_next, event_code, accepted, drive_level_next,
                   state_code(door_mode_next)};

  always_ff @(posedge clk) begin
    if (rst) begin
      door_mode       <= GATE_CLOSED;
      retreat_active  <= 1'b0;
      drive_level     <= DRIVE_STOP;
      travel_elapsed  <= '0;
      open_elapsed    <= '0;
      retreat_elapsed <= '0;
    end else if (in_fire) begin
      door_mode       <= door_mode_next;
      retreat_active  <= retreat_active_next;
      drive_level     <= drive_level_next;
      travel_elapsed  <= travel_elapsed_next;
      open_elapsed    <= open_elapsed_next;
      retreat_elapsed <= retreat_elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      // The main register is free this cycle: drain the skid entry first.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= result;
      end
    end else if (in_fire) begin
      skid_data <= result;
    end
  end

endmodule

>>> bench/gate_door_motion_controller_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate door motion controller testbench
// Streams door events through the block under random source gaps and sink
// stalls, predicts every result with its own door model and compares each
// one field by field. Runs a directed opening set, a long auto-close
// sequence and randomized phases with different timing settings.
// ----------------------------------------------------------------------------
module gate_door_motion_controller_unit_tb;
  import gdmc_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 20;
  localparam int RANDOM_PHASES  = 8;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [12:0] range_mm;
    logic        range_valid;
  } door_req_t;

  typedef struct packed {
    logic [2:0] state;
    logic [7:0] drive;
    logic       accepted;
    logic [1:0] evt;
    logic       backing;
  } door_result_t;

  logic clk;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [2:0]            s_axis_tuser = '0;

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  gate_door_motion_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Door model state and its copy of the timing registers.
  logic [2:0]            st_mode;
  logic                  st_retreat;
  logic signed [7:0]     st_drive;
  logic [TIME_W-1:0]     st_travel;
  logic [OPEN_EL_W-1:0]  st_open;
  logic [TIME_W-1:0]     st_backoff;
  logic [TIME_W-1:0]     set_open_travel;
  logic [TIME_W-1:0]     set_close_travel;
  logic [TIME_W-1:0]     set_retreat;
  logic [LIMIT_W-1:0]    set_limit;
  logic [AUTO_W-1:0]     set_auto;

  door_req_t    pending_req_q[$];
  door_result_t door_expect_q[$];
  door_req_t    drv_req;
  door_req_t    taken_req;
  door_result_t want;
  door_result_t got;

  logic req_fired = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   stall_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int   idle_cycles = 0;
  int   error_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic door_close();
    if (st_mode == STATE_BLOCKED || st_mode == STATE_FAULT) return 1'b0;
    if (st_mode == STATE_CLOSED || st_mode == STATE_CLOSING) return 1'b1;
    st_retreat = 1'b0;
    st_mode    = STATE_CLOSING;
    st_travel  = '0;
    st_open    = '0;
    st_drive   = DRIVE_CLOSE;
    return 1'b1;
  endfunction

  function automatic door_result_t door_step(door_req_t rq);
    door_result_t r;
    logic acc;
    logic [1:0] evt;
    acc = 1'b1;
    evt = EVT_NONE;
    case (rq.opcode)
      OP_TICK: begin
        if (st_mode == STATE_BLOCKED && st_retreat) begin
          if (st_backoff != TIME_MAX) st_backoff = st_backoff + 1'b1;
          if (st_backoff >= set_retreat) begin
            st_retreat = 1'b0;
            st_drive   = DRIVE_STOP;
          end
        end else if (st_mode == STATE_OPENING) begin
          if (st_travel != TIME_MAX) st_travel = st_travel + 1'b1;
          if (st_travel >= set_open_travel) begin
            st_drive = DRIVE_STOP;
            st_mode  = STATE_OPEN;
            st_open  = '0;
          end
        end else if (st_mode == STATE_CLOSING) begin
          if (st_travel != TIME_MAX) st_travel = st_travel + 1'b1;
          if (st_travel >= set_close_travel) begin
            st_drive = DRIVE_STOP;
            st_mode  = STATE_CLOSED;
            st_open  = '0;
          end
        end else if (st_mode == STATE_OPEN) begin
          if (st_open != OPEN_EL_MAX) st_open = st_open + 1'b1;
          if (set_auto != 0 && st_open >= set_auto * TICKS_PER_SECOND) begin
            void'(door_close());
            evt = EVT_AUTO_CLOSE;
          end
        end
      end
      OP_OPEN: begin
        if (st_mode == STATE_BLOCKED || st_mode == STATE_FAULT) begin
          acc = 1'b0;
        end else if (st_mode != STATE_OPEN && st_mode != STATE_OPENING) begin
          st_retreat = 1'b0;
          st_mode    = STATE_OPENING;
          st_travel  = '0;
          st_drive   = DRIVE_OPEN;
        end
      end
      OP_CLOSE: acc = door_close();
      OP_STOP: begin
        st_drive = DRIVE_STOP;
        if (st_mode == STATE_OPENING) begin
          st_mode = STATE_OPEN;
          st_open = '0;
        end else if (st_mode == STATE_CLOSING) begin
          st_mode = STATE_CLOSED;
          st_open = '0;
        end
      end
      OP_CLEAR: begin
        st_drive   = DRIVE_STOP;
        st_retreat = 1'b0;
        st_mode    = STATE_CLOSED;
        st_open    = '0;
      end
      OP_DISTANCE: begin
        if (st_mode == STATE_OPENING && rq.range_valid && rq.range_mm < set_limit) begin
          st_mode    = STATE_BLOCKED;
          st_retreat = 1'b1;
          st_backoff = '0;
          st_open    = '0;
          st_drive   = DRIVE_BACK;
          evt        = EVT_OBSTACLE;
        end
      end
      default: ;
    endcase
    r.state    = st_mode;
    r.drive    = st_drive;
    r.accepted = acc;
    r.evt      = evt;
    r.backing  = st_retreat;
    return r;
  endfunction

  function automatic void add_req(logic [2:0] op, logic [12:0] rng, logic vld);
    door_req_t rq;
    rq.opcode      = op;
    rq.range_mm    = rng;
    rq.range_valid = vld;
    pending_req_q.push_back(rq);
  endfunction

  function automatic logic [12:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TIME_MAX;
      default: return 13'($urandom_range(1, 12));
    endcase
  endfunction

  // Source: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_fired) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_req_q.size() != 0) begin
        drv_req = pending_req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, drv_req.range_valid, drv_req.range_mm};
        s_axis_tuser  <= drv_req.opcode;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: a rotating stall pattern, replaced by a new one whenever stall_left runs out.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left    <= 47;
      stall_pat     <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF));
      m_axis_tready <= 1'b1;
    end else begin
      stall_left    <= stall_left - 1;
      stall_pat     <= {stall_pat[0], stall_pat[15:1]};
      m_axis_tready <= stall_pat[0];
    end
  end

  // Monitor: predicts on each taken request and checks each delivered result.
  always @(posedge clk) begin
    if (rst) begin
      req_fired   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      req_fired <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        taken_req.opcode      = s_axis_tuser;
        taken_req.range_mm    = s_axis_tdata[12:0];
        taken_req.range_valid = s_axis_tdata[13];
        door_expect_q.push_back(door_step(taken_req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.state    = m_axis_tdata[2:0];
        got.drive    = m_axis_tdata[10:3];
        got.accepted = m_axis_tdata[11];
        got.evt      = m_axis_tdata[13:12];
        got.backing  = m_axis_tdata[14];
        if (door_expect_q.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: state %0d drive %0d", got.state, $signed(got.drive));
        end else begin
          want = door_expect_q.pop_front();
          if (got.state !== want.state || got.drive !== want.drive ||
              got.accepted !== want.accepted || got.evt !== want.evt ||
              got.backing !== want.backing) begin
            error_count = error_count + 1;
            if (error_count <= MAX_REPORTS) begin
              $display("mismatch: expected state %0d drive %0d acc %0b event %0d back %0b",
                       want.state, $signed(want.drive), want.accepted, want.evt, want.backing);
              $display("          actual   state %0d drive %0d acc %0b event %0d back %0b",
                       got.state, $signed(got.drive), got.accepted, got.evt, got.backing);
            end
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OPEN_TRAVEL:  set_open_travel  = val;
      REG_CLOSE_TRAVEL: set_close_travel = val;
      REG_RETREAT:      set_retreat      = val;
      REG_OBST_LIMIT:   set_limit        = val[LIMIT_W-1:0];
      REG_AUTO_CLOSE:   set_auto         = val[AUTO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued request has been sent and has produced its result.
  task automatic wait_drained();
    while (pending_req_q.size() != 0 || s_axis_tvalid || door_expect_q.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_all(logic [12:0] open_t, logic [12:0] close_t, logic [12:0] back_t,
                           logic [12:0] limit, logic [12:0] auto_s);
    write_reg(REG_OPEN_TRAVEL, open_t);
    write_reg(REG_CLOSE_TRAVEL, close_t);
    write_reg(REG_RETREAT, back_t);
    write_reg(REG_OBST_LIMIT, limit);
    write_reg(REG_AUTO_CLOSE, auto_s);
  endtask

  initial begin
    int w;
    logic [2:0]  op;
    logic [12:0] rng;
    st_mode    = STATE_CLOSED;
    st_retreat = 1'b0;
    st_drive   = DRIVE_STOP;
    st_travel  = '0;
    st_open    = '0;
    st_backoff = '0;
    set_open_travel  = 13'd1500;
    set_close_travel = 13'd1500;
    set_retreat      = 13'd800;
    set_limit        = 9'd80;
    set_auto         = 7'd30;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pass on the reset settings.
    add_req(OP_TICK, '0, 1'b0);
    add_req(OP_STOP, '0, 1'b0);
    add_req(OP_DISTANCE, '0, 1'b1);
    add_req(OP_CLOSE, '0, 1'b0);
    add_req(OP_OPEN, '0, 1'b0);
    add_req(OP_OPEN, '0, 1'b0);
    add_req(OP_DISTANCE, '0, 1'b0);
    add_req(OP_DISTANCE, 13'h1FFF, 1'b1);
    add_req(OP_DISTANCE, 13'd80, 1'b1);
    add_req(OP_DISTANCE, 13'd79, 1'b1);
    add_req(OP_OPEN, '0, 1'b0);
    add_req(OP_CLOSE, '0, 1'b0);
    add_req(OP_STOP, '0, 1'b0);
    add_req(OP_TICK, '0, 1'b0);
    add_req(OP_CLEAR, '0, 1'b0);
    add_req(OP_OPEN, '0, 1'b0);
    add_req(OP_CLOSE, '0, 1'b0);
    add_req(OP_OPEN, '0, 1'b0);
    add_req(OP_STOP, '0, 1'b0);
    add_req(OP_TICK, '0, 1'b0);
    add_req(OP_CLOSE, '0, 1'b0);
    add_req(OP_STOP, '0, 1'b0);
    add_req(OP_UNUSED_LO, 13'h1FFF, 1'b1);
    add_req(OP_UNUSED_HI, '0, 1'b1);
    wait_drained();

    // Zero travel and retreat times finish on the first tick.
    write_all('0, '0, '0, 13'd511, '0);
    add_req(OP_OPEN, '0, 1'b0);
    add_req(OP_TICK, '0, 1'b0);
    add_req(OP_CLOSE, '0, 1'b0);
    add_req(OP_TICK, '0, 1'b0);
    add_req(OP_OPEN, '0, 1'b0);
    add_req(OP_DISTANCE, 13'd510, 1'b1);
    add_req(OP_TICK, '0, 1'b0);
    add_req(OP_TICK, '0, 1'b0);
    add_req(OP_CLEAR, '0, 1'b0);
    wait_drained();
    write_reg(REG_OBST_LIMIT, '0);
    add_req(OP_OPEN, '0, 1'b0);
    add_req(OP_DISTANCE, '0, 1'b1);
    add_req(OP_CLEAR, '0, 1'b0);
    wait_drained();

    // Auto close switched on after the door has already been open a while;
    // the time spent open before counts toward the limit.
    write_all(13'd1, 13'd1, 13'd1, 13'd80, '0);
    add_req(OP_OPEN, '0, 1'b0);
    add_req(OP_TICK, '0, 1'b0);
    repeat (600) add_req(OP_TICK, '0, 1'b0);
    wait_drained();
    write_reg(REG_AUTO_CLOSE, 13'd1);
    repeat (TICKS_PER_SECOND - 600 + 1) add_req(OP_TICK, '0, 1'b0);
    wait_drained();

    // Randomized phases, each with its own timing settings.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        write_all(13'd5000, 13'd200, 13'd5000, 13'd30, 13'd120);
      else if (phase == 1)
        write_all(13'd200, 13'd5000, 13'd200, 13'd400, 13'd127);
      else
        write_all(pick_time(), pick_time(), pick_time(),
                  ($urandom_range(0, 3) == 0) ? 13'd511 : 13'($urandom_range(0, 400)),
                  ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 127)) : 13'd0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        w   = $urandom_range(0, 99);
        rng = 13'($urandom_range(0, 8191));
        if (w < 40)      op = OP_TICK;
        else if (w < 52) op = OP_OPEN;
        else if (w < 62) op = OP_CLOSE;
        else if (w < 68) op = OP_STOP;
        else if (w < 73) op = OP_CLEAR;
        else if (w < 95) op = OP_DISTANCE;
        else             op = w[0] ? OP_UNUSED_HI : OP_UNUSED_LO;
        // About half of the distance samples are drawn below the limit so that blocking happens often.
        if (op == OP_DISTANCE && set_limit != 0 && $urandom_range(0, 1) == 0)
          rng = 13'($urandom_range(0, set_limit - 1));
        add_req(op, rng, $urandom_range(0, 3) != 0);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0 && door_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
